// File: hdl/hha_pkg.sv
// package for the compacting handle heap allocator
// shared constants, codes, controller states and the controller/datapath command types
// no dependencies
package hha_pkg;

  localparam int HEAP_QUADS_DEF   = 1024;
  localparam int HANDLE_COUNT_DEF = 32;

  typedef enum logic [1:0] {
    ACT_ALLOC  = 2'd0,
    ACT_FREE   = 2'd1,
    ACT_CLEAR  = 2'd2,
    ACT_UNUSED = 2'd3
  } act_e;

  typedef enum logic [2:0] {
    STAT_OK       = 3'd0,
    STAT_NO_SPACE = 3'd1,
    STAT_INTERNAL = 3'd2,
    STAT_NOT_TEMP = 3'd3,
    STAT_EMPTY    = 3'd4
  } stat_e;

  typedef enum logic [3:0] {
    ST_INIT, ST_IDLE, ST_DECODE, ST_ALLOC_RD, ST_ALLOC_EV, ST_ALLOC_WR,
    ST_CF_RD, ST_CF_EV, ST_CU_RD, ST_CU_EV, ST_CU_WF, ST_FREE_EV, ST_REPLY
  } state_e;

  typedef enum logic [4:0] {
    DP_NONE, DP_INIT, DP_CLEAR, DP_ALLOC_START, DP_ALLOC_RD, DP_ALLOC_SKIP,
    DP_ALLOC_SPLIT, DP_ALLOC_COMMIT, DP_RETRY, DP_CF_START, DP_CF_RD,
    DP_CF_SKIP, DP_CF_FOUND, DP_CU_RD, DP_CU_MOVE, DP_CU_GAPW, DP_CU_MERGE,
    DP_FREE_RD, DP_FREE_COMMIT
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   ready;
    logic   emit;
    stat_e  status;
  } cmd_t;

  typedef struct packed {
    act_e act;
    logic has_slot;
    logic enough;
    logic hvalid;
    logic cur_ge;
    logic fr_ge;
    logic cu_ge;
    logic rd_used;
    logic fits;
    logic not_temp;
    logic pass;
    logic out_free;
  } sts_t;

endpackage

// File: hdl/hha_in_if.sv
// request channel of the heap allocator: valid/ready plus the request fields
// depends on nothing
interface hha_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [12:0] byte_length;
  logic        mark_temp;
  logic [4:0]  handle_index;
  logic        only_if_temp;

  modport source (output valid, action, byte_length, mark_temp, handle_index, only_if_temp,
                  input ready);
  modport sink (input valid, action, byte_length, mark_temp, handle_index, only_if_temp,
                output ready);
endinterface

// File: hdl/hha_out_if.sv
// result channel of the heap allocator: valid/ready plus the result fields
// depends on nothing
interface hha_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [2:0]  status;
  logic [4:0]  handle_out;
  logic [9:0]  data_quad;
  logic [9:0]  move_source;
  logic [9:0]  move_dest;
  logic [10:0] move_quads;
  logic        last;

  modport source (output valid, kind, status, handle_out, data_quad, move_source, move_dest,
                  move_quads, last, input ready);
  modport sink (input valid, kind, status, handle_out, data_quad, move_source, move_dest,
                move_quads, last, output ready);
endinterface

// File: hdl/hha_dp.sv
// datapath of the heap allocator: header memory, handle table, cursors, output register
// depends on hha_pkg; driven by hha_ctrl through cmd_t, reports through sts_t
module hha_dp #(
  parameter int HEAP_QUADS   = hha_pkg::HEAP_QUADS_DEF,
  parameter int HANDLE_COUNT = hha_pkg::HANDLE_COUNT_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  hha_pkg::cmd_t cmd_i,
  output hha_pkg::sts_t sts_o,
  input  logic          in_valid_i,
  input  logic [1:0]    action_i,
  input  logic [12:0]   byte_length_i,
  input  logic          mark_temp_i,
  input  logic [4:0]    handle_index_i,
  input  logic          only_if_temp_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic          kind_o,
  output logic [2:0]    status_o,
  output logic [4:0]    handle_out_o,
  output logic [9:0]    data_quad_o,
  output logic [9:0]    move_source_o,
  output logic [9:0]    move_dest_o,
  output logic [10:0]   move_quads_o,
  output logic          last_o
);
  import hha_pkg::*;

  localparam int AW = $clog2(HEAP_QUADS);
  localparam int LW = (AW + 1 > 13) ? AW + 1 : 13;
  localparam int CW = LW + 1;
  localparam int SW = (HANDLE_COUNT > 1) ? $clog2(HANDLE_COUNT) : 1;
  localparam int HW = LW + SW + 2;
  localparam int FW = $clog2(HEAP_QUADS + 1);

  logic [HW-1:0] mem [HEAP_QUADS];
  logic [HW-1:0] rd_q;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [HW-1:0] wr_data;

  logic [1:0]    act_q;
  logic [12:0]   len_q;
  logic          temp_q, tonly_q, pass_q, pass_d;
  logic [4:0]    hidx_q;
  logic [SW-1:0] slot_q, slot_d;
  logic [CW-1:0] cur_q, cur_d, fr_q, fr_d, cu_q, cu_d;
  logic [LW-1:0] flen_q, flen_d;
  logic [FW-1:0] fq_q, fq_d;
  logic [HANDLE_COUNT-1:0] valid_q, valid_d;
  logic [AW-1:0] squad_q [HANDLE_COUNT];

  logic          rd_used, rd_temp;
  logic [SW-1:0] rd_owner;
  logic [LW-1:0] rd_len, need, flen_sum;
  logic [CW-1:0] rd_span, rd_ext, hq, nx;
  logic [SW-1:0] free_slot;
  logic          has_slot;
  logic [5:0]    hidx6;
  logic [SW-1:0] hslot;
  logic          accept;

  logic          out_valid_q;
  logic          kind_q, last_q;
  logic [2:0]    status_q;
  logic [4:0]    handle_q;
  logic [9:0]    dq_q, src_q, dst_q;
  logic [10:0]   mq_q;

  assign rd_used  = rd_q[HW-1];
  assign rd_owner = rd_q[LW+1 +: SW];
  assign rd_temp  = rd_q[LW];
  assign rd_len   = rd_q[LW-1:0];
  assign rd_span  = CW'(rd_len >> 3) + CW'(2);
  assign rd_ext   = CW'(rd_len) + CW'(1);
  assign need     = LW'(len_q >> 3) + LW'(1);
  assign hq       = CW'(HEAP_QUADS);
  assign nx       = cur_q + CW'(need) + CW'(1);
  assign flen_sum = flen_q + LW'(rd_ext);
  assign hidx6    = {1'b0, hidx_q};
  assign hslot    = hidx6[SW-1:0];
  assign accept   = cmd_i.ready && in_valid_i;

  // lowest empty handle slot
  always_comb begin
    free_slot = '0;
    has_slot  = 1'b0;
    for (int i = HANDLE_COUNT - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_slot = SW'(i);
        has_slot  = 1'b1;
      end
    end
  end

  always_comb begin
    sts_o.act      = act_e'(act_q);
    sts_o.has_slot = has_slot;
    sts_o.enough   = CW'(fq_q) >= (CW'(len_q >> 3) + CW'(2));
    sts_o.hvalid   = (32'(hidx_q) < HANDLE_COUNT) && valid_q[hslot];
    sts_o.cur_ge   = cur_q >= hq;
    sts_o.fr_ge    = fr_q >= hq;
    sts_o.cu_ge    = cu_q >= hq;
    sts_o.rd_used  = rd_used;
    sts_o.fits     = rd_len >= need;
    sts_o.not_temp = tonly_q && !rd_temp;
    sts_o.pass     = pass_q;
    sts_o.out_free = !out_valid_q || out_ready_i;
  end

  // memory port selection and register updates per command
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = '0;
    cur_d   = cur_q;
    fr_d    = fr_q;
    cu_d    = cu_q;
    flen_d  = flen_q;
    fq_d    = fq_q;
    slot_d  = slot_q;
    pass_d  = pass_q;
    valid_d = valid_q;
    case (cmd_i.op)
      DP_INIT, DP_CLEAR: begin
        wr_en   = 1'b1;
        wr_data = {2'b00, {SW{1'b0}}, LW'(HEAP_QUADS - 1)};
        fq_d    = FW'(HEAP_QUADS);
        valid_d = '0;
      end
      DP_ALLOC_START: begin
        slot_d = free_slot;
        cur_d  = '0;
        pass_d = 1'b0;
      end
      DP_ALLOC_RD: begin
        rd_en   = 1'b1;
        rd_addr = cur_q[AW-1:0];
      end
      DP_ALLOC_SKIP: cur_d = cur_q + (rd_used ? rd_span : rd_ext);
      DP_ALLOC_SPLIT: begin
        if (rd_len > need && nx < hq) begin
          wr_en   = 1'b1;
          wr_addr = nx[AW-1:0];
          wr_data = {2'b00, {SW{1'b0}}, rd_len - LW'(1) - need};
        end
      end
      DP_ALLOC_COMMIT: begin
        wr_en           = 1'b1;
        wr_addr         = cur_q[AW-1:0];
        wr_data         = {1'b1, slot_q, temp_q, LW'(len_q)};
        valid_d[slot_q] = 1'b1;
        fq_d            = fq_q - FW'(need) - FW'(1);
      end
      DP_RETRY: begin
        cur_d  = '0;
        pass_d = 1'b1;
      end
      DP_CF_START: fr_d = '0;
      DP_CF_RD: begin
        rd_en   = 1'b1;
        rd_addr = fr_q[AW-1:0];
      end
      DP_CF_SKIP: fr_d = fr_q + rd_span;
      DP_CF_FOUND: begin
        flen_d = rd_len;
        cu_d   = fr_q + rd_ext;
      end
      DP_CU_RD: begin
        rd_en   = 1'b1;
        rd_addr = cu_q[AW-1:0];
      end
      DP_CU_MOVE: begin
        wr_en   = 1'b1;
        wr_addr = fr_q[AW-1:0];
        wr_data = {1'b1, rd_owner, rd_temp, rd_len};
        fr_d    = fr_q + rd_span;
        cu_d    = cu_q + rd_span;
      end
      DP_CU_GAPW: begin
        wr_en   = fr_q < hq;
        wr_addr = fr_q[AW-1:0];
        wr_data = {2'b00, {SW{1'b0}}, flen_q};
      end
      DP_CU_MERGE: begin
        flen_d  = flen_sum;
        wr_en   = fr_q < hq;
        wr_addr = fr_q[AW-1:0];
        wr_data = {2'b00, {SW{1'b0}}, flen_sum};
        cu_d    = cu_q + rd_ext;
      end
      DP_FREE_RD: begin
        rd_en   = 1'b1;
        rd_addr = squad_q[hslot];
      end
      DP_FREE_COMMIT: begin
        fq_d           = fq_q + FW'(rd_span);
        wr_en          = 1'b1;
        wr_addr        = squad_q[hslot];
        wr_data        = {2'b00, {SW{1'b0}}, LW'(rd_len >> 3) + LW'(1)};
        valid_d[hslot] = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      fq_q    <= FW'(HEAP_QUADS);
      pass_q  <= 1'b0;
    end else begin
      valid_q <= valid_d;
      fq_q    <= fq_d;
      pass_q  <= pass_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    fr_q   <= fr_d;
    cu_q   <= cu_d;
    flen_q <= flen_d;
    slot_q <= slot_d;
    if (accept) begin
      act_q   <= action_i;
      len_q   <= byte_length_i;
      temp_q  <= mark_temp_i;
      hidx_q  <= handle_index_i;
      tonly_q <= only_if_temp_i;
    end
    if (cmd_i.op == DP_ALLOC_COMMIT) squad_q[slot_q] <= cur_q[AW-1:0];
    if (cmd_i.op == DP_CU_MOVE && 32'(rd_owner) < HANDLE_COUNT) begin
      squad_q[rd_owner] <= fr_q[AW-1:0];
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      kind_q   <= 1'b0;
      status_q <= cmd_i.status;
      handle_q <= '0;
      dq_q     <= '0;
      src_q    <= '0;
      dst_q    <= '0;
      mq_q     <= '0;
      last_q   <= 1'b1;
      if (cmd_i.op == DP_ALLOC_COMMIT) begin
        handle_q <= 5'(slot_q);
        dq_q     <= 10'(cur_q + CW'(1));
      end else if (cmd_i.op == DP_CU_MOVE) begin
        kind_q   <= 1'b1;
        last_q   <= 1'b0;
        handle_q <= 5'(rd_owner);
        src_q    <= 10'(cu_q);
        dst_q    <= 10'(fr_q);
        mq_q     <= 11'(rd_span);
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign kind_o        = kind_q;
  assign status_o      = status_q;
  assign handle_out_o  = handle_q;
  assign data_quad_o   = dq_q;
  assign move_source_o = src_q;
  assign move_dest_o   = dst_q;
  assign move_quads_o  = mq_q;
  assign last_o        = last_q;

  // a new result is only loaded when the output register can take it
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> sts_o.out_free) else $error("result loaded over a pending one");
  // free credit never exceeds the heap size
  a_fq_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(fq_q) <= HEAP_QUADS) else $error("free quad count out of range");
  // a move command always leaves the write cursor below the read cursor
  a_move_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == DP_CU_MOVE |-> fr_q < cu_q) else $error("compaction cursors crossed");

endmodule

// File: hdl/hha_ctrl.sv
// controller of the heap allocator: sequences allocate, compaction, free and clear
// depends on hha_pkg; commands hha_dp through cmd_t
module hha_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  hha_pkg::sts_t sts_i,
  output hha_pkg::cmd_t cmd_o
);
  import hha_pkg::*;

  state_e state_q, state_d;
  stat_e  reply_q, reply_d;

  always_comb begin
    state_d = state_q;
    reply_d = reply_q;
    case (state_q)
      ST_INIT: state_d = ST_IDLE;
      ST_IDLE: if (in_valid_i) state_d = ST_DECODE;
      ST_DECODE: begin
        case (sts_i.act)
          ACT_ALLOC: begin
            if (!sts_i.has_slot || !sts_i.enough) begin
              reply_d = STAT_NO_SPACE;
              state_d = ST_REPLY;
            end else begin
              state_d = ST_ALLOC_RD;
            end
          end
          ACT_FREE: begin
            if (!sts_i.hvalid) begin
              reply_d = STAT_EMPTY;
              state_d = ST_REPLY;
            end else begin
              state_d = ST_FREE_EV;
            end
          end
          default: begin
            reply_d = STAT_OK;
            state_d = ST_REPLY;
          end
        endcase
      end
      ST_ALLOC_RD: begin
        if (!sts_i.cur_ge) begin
          state_d = ST_ALLOC_EV;
        end else if (!sts_i.pass) begin
          state_d = ST_CF_RD;
        end else begin
          reply_d = STAT_INTERNAL;
          state_d = ST_REPLY;
        end
      end
      ST_ALLOC_EV: state_d = (!sts_i.rd_used && sts_i.fits) ? ST_ALLOC_WR : ST_ALLOC_RD;
      ST_ALLOC_WR: if (sts_i.out_free) state_d = ST_IDLE;
      ST_CF_RD:    state_d = sts_i.fr_ge ? ST_ALLOC_RD : ST_CF_EV;
      ST_CF_EV:    state_d = sts_i.rd_used ? ST_CF_RD : ST_CU_RD;
      ST_CU_RD:    state_d = sts_i.cu_ge ? ST_ALLOC_RD : ST_CU_EV;
      ST_CU_EV: begin
        if (!sts_i.rd_used) state_d = ST_CU_RD;
        else if (sts_i.out_free) state_d = ST_CU_WF;
      end
      ST_CU_WF:    state_d = ST_CU_RD;
      ST_FREE_EV:  if (sts_i.out_free) state_d = ST_IDLE;
      ST_REPLY:    if (sts_i.out_free) state_d = ST_IDLE;
      default:     state_d = ST_INIT;
    endcase
  end

  always_comb begin
    cmd_o.op     = DP_NONE;
    cmd_o.ready  = 1'b0;
    cmd_o.emit   = 1'b0;
    cmd_o.status = STAT_OK;
    case (state_q)
      ST_INIT: cmd_o.op = DP_INIT;
      ST_IDLE: cmd_o.ready = 1'b1;
      ST_DECODE: begin
        case (sts_i.act)
          ACT_ALLOC: if (sts_i.has_slot && sts_i.enough) cmd_o.op = DP_ALLOC_START;
          ACT_FREE:  if (sts_i.hvalid) cmd_o.op = DP_FREE_RD;
          ACT_CLEAR: cmd_o.op = DP_CLEAR;
          default:   cmd_o.op = DP_NONE;
        endcase
      end
      ST_ALLOC_RD: begin
        if (!sts_i.cur_ge) cmd_o.op = DP_ALLOC_RD;
        else if (!sts_i.pass) cmd_o.op = DP_CF_START;
      end
      ST_ALLOC_EV: cmd_o.op = (!sts_i.rd_used && sts_i.fits) ? DP_ALLOC_SPLIT : DP_ALLOC_SKIP;
      ST_ALLOC_WR: begin
        if (sts_i.out_free) begin
          cmd_o.op   = DP_ALLOC_COMMIT;
          cmd_o.emit = 1'b1;
        end
      end
      ST_CF_RD: cmd_o.op = sts_i.fr_ge ? DP_RETRY : DP_CF_RD;
      ST_CF_EV: cmd_o.op = sts_i.rd_used ? DP_CF_SKIP : DP_CF_FOUND;
      ST_CU_RD: cmd_o.op = sts_i.cu_ge ? DP_RETRY : DP_CU_RD;
      ST_CU_EV: begin
        if (!sts_i.rd_used) begin
          cmd_o.op = DP_CU_MERGE;
        end else if (sts_i.out_free) begin
          cmd_o.op   = DP_CU_MOVE;
          cmd_o.emit = 1'b1;
        end
      end
      ST_CU_WF: cmd_o.op = DP_CU_GAPW;
      ST_FREE_EV: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.not_temp) cmd_o.status = STAT_NOT_TEMP;
          else cmd_o.op = DP_FREE_COMMIT;
        end
      end
      ST_REPLY: begin
        if (sts_i.out_free) begin
          cmd_o.emit   = 1'b1;
          cmd_o.status = reply_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
      reply_q <= STAT_OK;
    end else begin
      state_q <= state_d;
      reply_q <= reply_d;
    end
  end

  // an accepted request is decoded in the following cycle
  a_decode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.ready && in_valid_i) |=> state_q == ST_DECODE) else $error("request not decoded");
  // a final answer returns the controller to idle
  a_final_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.emit && cmd_o.op != DP_CU_MOVE) |=> state_q == ST_IDLE)
    else $error("final answer without return to idle");
  // move commands only come out of compaction
  a_move_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.op == DP_CU_MOVE |-> state_q == ST_CU_EV) else $error("move outside compaction");

endmodule

// File: hdl/handle_heap_allocator_compacting.sv
// Handle-based first-fit heap allocator over 8-byte quads, with compaction.
// Requests come in on in_i (valid/ready): allocate, free or clear. Every request
// yields one final answer on out_o with last set; an allocate that has to compact
// first sends one move command (kind 1) per slid block ahead of its answer.
// Requests are taken one at a time: in_i.ready is high only while the block is idle.
// Free, clear and rejected requests pass through a decode state and then an answer
// state that loads the result. Allocate walks the block headers, reading and then
// evaluating each visited block; compaction also reads and evaluates each block,
// adds a gap-write state per used block, and a second walk follows.
// A stalled out_o holds its result; the controller waits before loading the next
// one, so nothing is lost. After reset the init state writes the initial free header
// of quad 0, then in_i.ready rises; clear rewrites the same header.
// Depends on hha_pkg, hha_in_if, hha_out_if, hha_ctrl and hha_dp.
module handle_heap_allocator_compacting #(
  parameter int HEAP_QUADS   = hha_pkg::HEAP_QUADS_DEF,
  parameter int HANDLE_COUNT = hha_pkg::HANDLE_COUNT_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  hha_in_if.sink    in_i,
  hha_out_if.source out_o
);
  import hha_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign in_i.ready = cmd.ready;

  hha_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  hha_dp #(
    .HEAP_QUADS   (HEAP_QUADS),
    .HANDLE_COUNT (HANDLE_COUNT)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .in_valid_i     (in_i.valid),
    .action_i       (in_i.action),
    .byte_length_i  (in_i.byte_length),
    .mark_temp_i    (in_i.mark_temp),
    .handle_index_i (in_i.handle_index),
    .only_if_temp_i (in_i.only_if_temp),
    .out_valid_o    (out_o.valid),
    .out_ready_i    (out_o.ready),
    .kind_o         (out_o.kind),
    .status_o       (out_o.status),
    .handle_out_o   (out_o.handle_out),
    .data_quad_o    (out_o.data_quad),
    .move_source_o  (out_o.move_source),
    .move_dest_o    (out_o.move_dest),
    .move_quads_o   (out_o.move_quads),
    .last_o         (out_o.last)
  );

endmodule
